/* design/jrda_pkg.sv */
// Shared types and constants for the joystick radial dead zone / angle block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package jrda_pkg;

	localparam int AXIS_W    = 16;
	localparam int DZ_W      = 15;
	localparam int ANG_W     = 17;
	localparam int SQ_W      = 32;
	localparam int ACC_FRAC  = 16;
	localparam int ACC_W     = 26;
	localparam int CW        = 19;
	localparam int ANGLE_ITERATIONS = 16;
	localparam int ANGLE_FRAC_BITS  = 8;
	localparam int ITER_W    = $clog2(ANGLE_ITERATIONS);
	localparam int TAB_LEN   = 24;
	localparam int TAB_IW    = $clog2(TAB_LEN);
	localparam int OUT_W     = 56;

	localparam logic [DZ_W-1:0] DZ_RESET = DZ_W'(8000);

	// input kinds
	localparam logic [1:0] KIND_SET_X = 2'd0;
	localparam logic [1:0] KIND_SET_Y = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	localparam logic signed [ACC_W-1:0] DEG90  = ACC_W'(90 <<< ACC_FRAC);
	localparam logic signed [ACC_W-1:0] DEG180 = ACC_W'(180 <<< ACC_FRAC);

	// atan(2^-i) in degrees, 16 fraction bits
	localparam logic [22:0] ATAN_TAB [TAB_LEN] = '{
		23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
		23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
		23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
		23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
	};

	typedef struct packed {
		logic              load;
		logic              step;
		logic [ITER_W-1:0] iter;
	} jrda_cordic_ctl_t;

endpackage

/* design/jrda_mult.sv */
// Shared 16x16 signed multiplier with registered product.
// Depends on jrda_pkg.
`timescale 1ns / 1ps
module jrda_mult (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [jrda_pkg::AXIS_W-1:0] a,
	input  logic signed [jrda_pkg::AXIS_W-1:0] b,
	output logic signed [jrda_pkg::SQ_W-1:0]   p_q
);
	import jrda_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

/* design/jrda_cordic.sv */
// Iterative CORDIC vectoring unit: one micro-rotation per step, then round/clamp.
// Depends on jrda_pkg.
`timescale 1ns / 1ps
module jrda_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  jrda_pkg::jrda_cordic_ctl_t         ctl,
	input  logic signed [jrda_pkg::AXIS_W-1:0] x_in,
	input  logic signed [jrda_pkg::AXIS_W-1:0] y_in,
	output logic signed [jrda_pkg::ANG_W-1:0]  angle
);
	import jrda_pkg::*;

	localparam int RS = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam int RW = ACC_W + 1;
	localparam logic signed [RW-1:0] LIM  = RW'(180 <<< ANGLE_FRAC_BITS);
	localparam logic signed [RW-1:0] HALF = RW'(1 <<< (RS - 1));

	logic signed [CW-1:0]    x_q, y_q, xs, ys, xe, ye;
	logic signed [ACC_W-1:0] acc_q, tab;
	logic                    fixed_q;
	logic signed [RW-1:0]    sum, rnd;

	assign xe  = CW'(x_in);
	assign ye  = CW'(y_in);
	assign xs  = x_q >>> ctl.iter;
	assign ys  = y_q >>> ctl.iter;
	assign tab = ACC_W'(ATAN_TAB[TAB_IW'(ctl.iter)]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_q <= 1'b1;
		end else if (ctl.load) begin
			fixed_q <= (y_in == '0) || (x_in == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (y_in == '0) begin
				acc_q <= x_in[AXIS_W-1] ? DEG180 : '0;
			end else if (x_in == '0) begin
				acc_q <= y_in[AXIS_W-1] ? -DEG90 : DEG90;
			end else if (x_in[AXIS_W-1] && !y_in[AXIS_W-1]) begin
				// left half, upper: turn by -90
				x_q   <= ye;
				y_q   <= -xe;
				acc_q <= DEG90;
			end else if (x_in[AXIS_W-1]) begin
				x_q   <= -ye;
				y_q   <= xe;
				acc_q <= -DEG90;
			end else begin
				x_q   <= xe;
				y_q   <= ye;
				acc_q <= '0;
			end
		end else if (ctl.step && !fixed_q) begin
			if (!y_q[CW-1]) begin
				x_q   <= x_q + ys;
				y_q   <= y_q - xs;
				acc_q <= acc_q + tab;
			end else begin
				x_q   <= x_q - ys;
				y_q   <= y_q + xs;
				acc_q <= acc_q - tab;
			end
		end
	end

	// round half up, then clamp to +180 and fold the -180 end onto +180
	assign sum = RW'(acc_q) + HALF;
	assign rnd = sum >>> RS;

	always_comb begin
		if (rnd > LIM || rnd <= -LIM) begin
			angle = ANG_W'(LIM);
		end else begin
			angle = ANG_W'(rnd);
		end
	end

endmodule

/* design/joystick_radial_deadzone_angle_top.sv */
// Top level: axis registers, dead-zone test and sequencer around shared units.
// Depends on jrda_pkg, jrda_mult, jrda_cordic.
//
//  channel   dir  handshake                       contents
//  s_axis    in   s_axis_tvalid/s_axis_tready     tdata: axis_value; tuser: kind
//  m_axis    out  m_axis_tvalid/m_axis_tready     tdata: angle,x_out,y_out; tuser: changed
//  cfg       in   cfg_valid/cfg_ready             cfg_data: dead_zone
//
// Axis updates are written straight into the axis registers. After a tick is
// taken, the block runs the radius test (x^2, y^2, radius^2 on the shared
// multiplier, compare), one CORDIC load, 16 CORDIC steps, and then loads the
// output word; the next input is taken once it is back in S_IDLE. Input is not
// taken while a tick is in work; a held output word only stalls the last step.
// Reset clears the axes and sets the radius to 8000.
`timescale 1ns / 1ps
module joystick_radial_deadzone_angle_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [jrda_pkg::AXIS_W-1:0]      s_axis_tdata,  // [15:0] axis_value
	input  logic [1:0]                       s_axis_tuser,  // [1:0] kind
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [16:0] angle, [32:17] x_out, [48:33] y_out, [55:49] zero
	output logic [jrda_pkg::OUT_W-1:0]       m_axis_tdata,
	output logic                             m_axis_tuser,  // [0] changed
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [jrda_pkg::DZ_W-1:0]        cfg_data
);
	import jrda_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_SQX, S_SQY, S_SUM, S_CMP, S_LOAD, S_ITER, S_OUT
	} state_t;

	state_t                   state_q;
	logic [DZ_W-1:0]          dead_zone_q;
	logic signed [AXIS_W-1:0] x_now_q, y_now_q, x_before_q, y_before_q;
	logic [SQ_W-1:0]          mag_q;
	logic [ITER_W-1:0]        iter_q;
	logic                     m_valid_q, changed_q;
	logic [OUT_W-1:0]         out_data_q;
	logic                     mul_en;
	logic signed [AXIS_W-1:0] mul_a;
	logic signed [SQ_W-1:0]   prod;
	logic signed [ANG_W-1:0]  angle;
	jrda_cordic_ctl_t         cctl;
	logic                     in_acc, out_free;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = changed_q;
	assign out_free      = !m_valid_q || m_axis_tready;

	// squaring operand per state
	always_comb begin
		mul_en = 1'b1;
		unique case (state_q)
			S_SQX:   mul_a = x_now_q;
			S_SQY:   mul_a = y_now_q;
			S_SUM:   mul_a = AXIS_W'(dead_zone_q);
			default: begin
				mul_a  = '0;
				mul_en = 1'b0;
			end
		endcase
	end

	jrda_mult u_mult (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_a),
		.p_q (prod)
	);

	assign cctl.load = (state_q == S_LOAD);
	assign cctl.step = (state_q == S_ITER);
	assign cctl.iter = iter_q;

	jrda_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.x_in   (x_now_q),
		.y_in   (y_now_q),
		.angle  (angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= DZ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dead_zone_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			x_now_q    <= '0;
			y_now_q    <= '0;
			x_before_q <= '0;
			y_before_q <= '0;
			iter_q     <= '0;
			m_valid_q  <= 1'b0;
			changed_q  <= 1'b0;
		end else begin
			// in S_OUT the valid flag is handled by the output load below
			if (m_valid_q && m_axis_tready && state_q != S_OUT) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (s_axis_tuser)
							KIND_SET_X: x_now_q <= s_axis_tdata;
							KIND_SET_Y: y_now_q <= s_axis_tdata;
							KIND_TICK:  state_q <= S_SQX;
							default:    ;
						endcase
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: state_q <= S_SUM;
				S_SUM: state_q <= S_CMP;
				S_CMP: begin
					if (mag_q < SQ_W'(prod)) begin
						x_now_q <= '0;
						y_now_q <= '0;
					end
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					iter_q  <= '0;
					state_q <= S_ITER;
				end
				S_ITER: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_W'(ANGLE_ITERATIONS - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_valid_q  <= 1'b1;
						changed_q  <= (x_now_q != x_before_q) || (y_now_q != y_before_q);
						x_before_q <= x_now_q;
						y_before_q <= y_now_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// magnitude accumulate and output word
	always_ff @(posedge clk) begin
		if (state_q == S_SQY) begin
			mag_q <= SQ_W'(prod);
		end else if (state_q == S_SUM) begin
			mag_q <= mag_q + SQ_W'(prod);
		end
		if (state_q == S_OUT && out_free) begin
			out_data_q <= {7'b0, y_now_q, x_now_q, angle};
		end
	end

endmodule
